// ----- hw/rtl/ldis_pkg.sv -----
// shared types, constants and codes of the lidar depth image splatter
package ldis_pkg;

  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 9;
  localparam int MAX_WIDTH  = 1 << COL_BITS;
  localparam int MAX_HEIGHT = 1 << ROW_BITS;
  localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  localparam int COORD_BITS = 18;
  localparam int SUMSQ_BITS = 2 * COORD_BITS;
  localparam int ROOT_BITS  = COORD_BITS;
  localparam int SQRT_REM_BITS = ROOT_BITS + 3;

  localparam int DIST_BITS  = 18;
  localparam int FW_BITS    = 11;
  localparam int FH_BITS    = 10;
  localparam int GREY_BITS  = 8;
  localparam int NUM_BITS   = DIST_BITS + GREY_BITS;

  localparam int OP_BITS       = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 18;

  typedef logic [OP_BITS-1:0]           op_t;
  typedef logic [COL_BITS-1:0]          col_t;
  typedef logic [ROW_BITS-1:0]          row_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [GREY_BITS-1:0]         grey_t;
  typedef logic [DIST_BITS-1:0]         dist_t;
  typedef logic [FW_BITS-1:0]           fw_t;
  typedef logic [FH_BITS-1:0]           fh_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;

  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_PLOT  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam cfg_idx_t REG_MAX_DISTANCE = 2'd0;
  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd1;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd2;

  localparam dist_t MAX_DISTANCE_RST = 18'd50000;
  localparam fw_t   FRAME_WIDTH_RST  = 11'd1024;
  localparam fh_t   FRAME_HEIGHT_RST = 10'd512;

  localparam grey_t GREY_MAX = 8'd255;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    dist_t  max_dist;
  } dist_req_t;

  typedef struct packed {
    logic  done;
    grey_t grey;
  } dist_rsp_t;

endpackage

// ----- hw/rtl/ldis_ifs.sv -----
// valid/ready channel interfaces of the splatter: command, result and register write
interface ldis_in_if;
  logic                 valid;
  logic                 ready;
  ldis_pkg::op_t        op;
  ldis_pkg::col_t       pixel_col;
  ldis_pkg::row_t       pixel_row;
  ldis_pkg::coord_t     point_x;
  ldis_pkg::coord_t     point_y;
  ldis_pkg::coord_t     point_z;

  modport source (output valid, op, pixel_col, pixel_row, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, op, pixel_col, pixel_row, point_x, point_y, point_z,
                output ready);
endinterface

interface ldis_out_if;
  logic                 valid;
  logic                 ready;
  ldis_pkg::grey_t      pixel_value;
  logic                 point_dropped;

  modport source (output valid, pixel_value, point_dropped, input ready);
  modport sink (input valid, pixel_value, point_dropped, output ready);
endinterface

interface ldis_cfg_if;
  logic                 valid;
  logic                 ready;
  ldis_pkg::cfg_idx_t   index;
  ldis_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ldis_dist_unit.sv -----
// range-to-grey unit: squares, bit-serial square root and division on one shared subtractor
module ldis_dist_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ldis_pkg::dist_req_t req,
  output ldis_pkg::dist_rsp_t rsp
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_SQ   = 3'd1;
  localparam logic [2:0] A_SQRT = 3'd2;
  localparam logic [2:0] A_CHK  = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_DONE = 3'd5;

  localparam int MAG_BITS   = ldis_pkg::COORD_BITS;
  localparam int SUB_BITS   = ldis_pkg::NUM_BITS;
  localparam int SQ_LAST    = 3;
  localparam int SQRT_LAST  = ldis_pkg::ROOT_BITS - 1;
  localparam int DIV_LAST   = ldis_pkg::GREY_BITS - 1;

  function automatic logic [MAG_BITS-1:0] magnitude(input ldis_pkg::coord_t v);
    logic [MAG_BITS-1:0] u;
    u = MAG_BITS'(v);
    return u[MAG_BITS-1] ? (~u + MAG_BITS'(1)) : u;
  endfunction

  logic [2:0]                        state_r, state_nxt;
  logic [4:0]                        step_r, step_nxt;
  logic [MAG_BITS-1:0]               mag_x_r, mag_y_r, mag_z_r;
  logic [MAG_BITS-1:0]               mag_x_nxt, mag_y_nxt, mag_z_nxt;
  logic [ldis_pkg::SUMSQ_BITS-1:0]   prod_r, prod_nxt;
  logic [ldis_pkg::SUMSQ_BITS-1:0]   acc_r, acc_nxt;
  logic [ldis_pkg::ROOT_BITS-1:0]    root_r, root_nxt;
  logic [SUB_BITS-1:0]               rem_r, rem_nxt;
  logic [SUB_BITS-1:0]               dsh_r, dsh_nxt;
  logic [ldis_pkg::GREY_BITS-1:0]    q_r, q_nxt;
  ldis_pkg::dist_t                   max_r, max_nxt;
  ldis_pkg::grey_t                   grey_r, grey_nxt;

  logic [MAG_BITS-1:0]               mul_op;
  logic [ldis_pkg::SQRT_REM_BITS-1:0] sq_in;
  logic [SUB_BITS-1:0]               sub_a, sub_b;
  logic [SUB_BITS:0]                 diff;
  logic                              ge;
  logic [SUB_BITS-1:0]               root_w;
  logic [SUB_BITS-1:0]               num;
  logic [ldis_pkg::GREY_BITS-1:0]    q_last;

  // bring down the next two radicand bits
  assign sq_in = {rem_r[ldis_pkg::SQRT_REM_BITS-3:0],
                  acc_r[ldis_pkg::SUMSQ_BITS-1 -: 2]};

  // shared compare-subtract: trial remainder for the root, divisor for the quotient
  always_comb begin
    sub_a = rem_r;
    sub_b = dsh_r;
    if (state_r == A_SQRT) begin
      sub_a = SUB_BITS'(sq_in);
      sub_b = SUB_BITS'({root_r, 2'b01});
    end
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[SUB_BITS];

  // 255*d + m - 1, rounds the quotient up
  assign root_w = SUB_BITS'(root_r);
  assign num    = (root_w << ldis_pkg::GREY_BITS) - root_w + SUB_BITS'(max_r)
                  - SUB_BITS'(1);
  assign q_last = {q_r[ldis_pkg::GREY_BITS-2:0], ge};

  always_comb begin
    unique case (step_r[1:0])
      2'd0:    mul_op = mag_x_r;
      2'd1:    mul_op = mag_y_r;
      default: mul_op = mag_z_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mag_x_nxt = mag_x_r;
    mag_y_nxt = mag_y_r;
    mag_z_nxt = mag_z_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    max_nxt   = max_r;
    grey_nxt  = grey_r;
    unique case (state_r)
      A_IDLE: begin
        if (start) begin
          mag_x_nxt = magnitude(req.x);
          mag_y_nxt = magnitude(req.y);
          mag_z_nxt = magnitude(req.z);
          max_nxt   = req.max_dist;
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = A_SQ;
        end
      end
      A_SQ: begin
        prod_nxt = mul_op * mul_op;
        if (step_r != '0) begin
          acc_nxt = acc_r + prod_r;
        end
        if (step_r == 5'(SQ_LAST)) begin
          root_nxt  = '0;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = A_SQRT;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      A_SQRT: begin
        acc_nxt = acc_r << 2;
        if (ge) begin
          rem_nxt  = diff[SUB_BITS-1:0];
          root_nxt = {root_r[ldis_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_nxt  = SUB_BITS'(sq_in);
          root_nxt = {root_r[ldis_pkg::ROOT_BITS-2:0], 1'b0};
        end
        if (step_r == 5'(SQRT_LAST)) begin
          state_nxt = A_CHK;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      A_CHK: begin
        // also covers a zero maximum distance
        if (root_r >= max_r) begin
          grey_nxt  = '0;
          state_nxt = A_DONE;
        end else begin
          rem_nxt   = num;
          dsh_nxt   = SUB_BITS'({max_r, {(ldis_pkg::GREY_BITS-1){1'b0}}});
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = A_DIV;
        end
      end
      A_DIV: begin
        if (ge) begin
          rem_nxt = diff[SUB_BITS-1:0];
        end
        q_nxt   = q_last;
        dsh_nxt = dsh_r >> 1;
        if (step_r == 5'(DIV_LAST)) begin
          grey_nxt  = ldis_pkg::GREY_MAX - q_last;
          state_nxt = A_DONE;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      A_DONE: begin
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    mag_x_r <= mag_x_nxt;
    mag_y_r <= mag_y_nxt;
    mag_z_r <= mag_z_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    root_r  <= root_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    q_r     <= q_nxt;
    max_r   <= max_nxt;
    grey_r  <= grey_nxt;
  end

  assign rsp.done = (state_r == A_DONE);
  assign rsp.grey = grey_r;

endmodule

// ----- hw/rtl/lidar_depth_image_splatter.sv -----
// top level of the lidar depth image splatter: frame store, command sequencer, registers
//
// in_if carries one command word: clear the frame, plot a point, or read a pixel back.
// out_if returns exactly one result word per command: the grey value that was plotted
// or read, and a flag set when the pixel lies outside the frame in use.
// cfg_if writes max_distance, frame_width and frame_height; it is always ready. The user
// must write it only while no command is in flight; the block does not enforce this.
// one command is handled at a time; in_if.ready is high only while idle.
// plot: the squares of the coordinates, an 18-step square root and an 8-step division
// (the last two on one shared subtractor); the division is skipped when the range is at
// or beyond max_distance. read: the frame store read port is registered, so a read
// passes S_RD and S_RDW before S_FIN. out of frame or unused command: straight to S_FIN.
// clear: one frame store byte written per cycle.
// after reset the same clearing pass runs with in_if.ready low.
// the result sits in an output register; the next command is accepted while it waits,
// and a finished result holds its sequencer until out_if.ready frees the register.
module lidar_depth_image_splatter (
  input  logic              clk,
  input  logic              rst_n,
  ldis_in_if.sink           in_if,
  ldis_out_if.source        out_if,
  ldis_cfg_if.sink          cfg_if
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PLOT = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  ldis_pkg::addr_t       clr_addr_r, clr_addr_nxt;
  logic                  clr_reply_r, clr_reply_nxt;
  ldis_pkg::addr_t       addr_r, addr_nxt;
  ldis_pkg::grey_t       value_r, value_nxt;
  logic                  dropped_r, dropped_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ldis_pkg::grey_t       out_value_r, out_value_nxt;
  logic                  out_dropped_r, out_dropped_nxt;
  ldis_pkg::dist_t       max_dist_r;
  ldis_pkg::fw_t         frame_width_r;
  ldis_pkg::fh_t         frame_height_r;

  ldis_pkg::grey_t       frame_mem [ldis_pkg::DEPTH];
  ldis_pkg::grey_t       mem_q_r;
  logic                  mem_we;
  logic                  mem_re;
  ldis_pkg::addr_t       mem_waddr;
  ldis_pkg::grey_t       mem_wdata;

  logic                  in_fire;
  logic                  in_inside;
  logic                  out_load;
  logic                  dist_start;
  ldis_pkg::dist_req_t   dist_req;
  ldis_pkg::dist_rsp_t   dist_rsp;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  // column and row are always below the store size, so the limit is just the register
  assign in_inside = ({1'b0, in_if.pixel_col} < frame_width_r) &&
                     ({1'b0, in_if.pixel_row} < frame_height_r);

  assign dist_start        = in_fire && (in_if.op == ldis_pkg::OP_PLOT) && in_inside;
  assign dist_req.x        = in_if.point_x;
  assign dist_req.y        = in_if.point_y;
  assign dist_req.z        = in_if.point_z;
  assign dist_req.max_dist = max_dist_r;

  ldis_dist_unit u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dist_start),
    .req   (dist_req),
    .rsp   (dist_rsp)
  );

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    addr_nxt      = addr_r;
    value_nxt     = value_r;
    dropped_nxt   = dropped_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = clr_addr_r;
    mem_wdata     = '0;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (clr_addr_r == '1) begin
          clr_reply_nxt = 1'b0;
          state_nxt     = clr_reply_r ? S_FIN : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ldis_pkg::ADDR_BITS'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          addr_nxt    = {in_if.pixel_row, in_if.pixel_col};
          value_nxt   = '0;
          dropped_nxt = 1'b0;
          unique case (in_if.op)
            ldis_pkg::OP_CLEAR: begin
              clr_addr_nxt  = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            ldis_pkg::OP_PLOT: begin
              dropped_nxt = !in_inside;
              state_nxt   = in_inside ? S_PLOT : S_FIN;
            end
            ldis_pkg::OP_READ: begin
              dropped_nxt = !in_inside;
              state_nxt   = in_inside ? S_RD : S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_PLOT: begin
        if (dist_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = dist_rsp.grey;
          value_nxt = dist_rsp.grey;
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        value_nxt = mem_q_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    out_dropped_nxt = out_dropped_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_value_nxt   = value_r;
      out_dropped_nxt = dropped_r;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r        <= addr_nxt;
    value_r       <= value_nxt;
    dropped_r     <= dropped_nxt;
    out_value_r   <= out_value_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= frame_mem[addr_r];
    end
  end

  // register writes
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r     <= ldis_pkg::MAX_DISTANCE_RST;
      frame_width_r  <= ldis_pkg::FRAME_WIDTH_RST;
      frame_height_r <= ldis_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        ldis_pkg::REG_MAX_DISTANCE: max_dist_r     <= cfg_if.data[ldis_pkg::DIST_BITS-1:0];
        ldis_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_if.data[ldis_pkg::FW_BITS-1:0];
        ldis_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_if.data[ldis_pkg::FH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.pixel_value   = out_value_r;
  assign out_if.point_dropped = out_dropped_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("frame store written while idle");

  a_dist_done_in_plot: assert property (@(posedge clk) disable iff (!rst_n)
    dist_rsp.done |-> (state_r == S_PLOT))
    else $error("distance unit finished outside a plot");

  a_drop_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_inside &&
     ((in_if.op == ldis_pkg::OP_PLOT) || (in_if.op == ldis_pkg::OP_READ)))
    |=> ((state_r == S_FIN) && dropped_r))
    else $error("out of frame command not flagged");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && !out_valid_r) |=> out_valid_r)
    else $error("finished result not presented");

endmodule

// ----- test/tb_top.sv -----
// testbench of the lidar depth image splatter: predicted pixel results checked word by word
`timescale 1ns / 1ps

module tb_top;

  localparam ldis_pkg::op_t OP_UNUSED = 2'd3;
  localparam int            PHASES    = 12;

  typedef struct {
    ldis_pkg::grey_t value;
    logic            dropped;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ldis_in_if  in_ch ();
  ldis_out_if out_ch ();
  ldis_cfg_if cfg_ch ();

  lidar_depth_image_splatter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the block state and registers
  ldis_pkg::grey_t frame_mirror [int unsigned];
  ldis_pkg::dist_t max_dist_cfg = ldis_pkg::MAX_DISTANCE_RST;
  ldis_pkg::fw_t   width_cfg    = ldis_pkg::FRAME_WIDTH_RST;
  ldis_pkg::fh_t   height_cfg   = ldis_pkg::FRAME_HEIGHT_RST;

  pixel_result_t pixel_results_due [$];

  bit idle_on = 1'b1;
  int mismatches, results_seen;
  int plots_sent, reads_sent, drops_sent, clears_sent, unused_sent;

  task automatic report_mismatch(string what);
    if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic longint unsigned coord_sq(ldis_pkg::coord_t c);
    longint signed v;
    v = c;
    if (v < 0) v = -v;
    return v * v;
  endfunction

  // floor square root, one result bit per pass
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic ldis_pkg::grey_t grey_of_range(longint unsigned d);
    longint unsigned m;
    m = max_dist_cfg;
    if (d >= m) return '0;
    return ldis_pkg::grey_t'(ldis_pkg::GREY_MAX -
                             (ldis_pkg::GREY_MAX * d + m - 1) / m);
  endfunction

  function automatic pixel_result_t splat_predict(ldis_pkg::op_t op, ldis_pkg::col_t col,
                                                  ldis_pkg::row_t row,
                                                  ldis_pkg::coord_t x, ldis_pkg::coord_t y,
                                                  ldis_pkg::coord_t z);
    pixel_result_t r;
    int unsigned w_use, h_use, addr;
    logic in_frame;
    r.value = '0;
    r.dropped = 1'b0;
    w_use = (width_cfg < ldis_pkg::MAX_WIDTH) ? width_cfg : ldis_pkg::MAX_WIDTH;
    h_use = (height_cfg < ldis_pkg::MAX_HEIGHT) ? height_cfg : ldis_pkg::MAX_HEIGHT;
    in_frame = (col < w_use) && (row < h_use);
    addr = row * ldis_pkg::MAX_WIDTH + col;
    case (op)
      ldis_pkg::OP_CLEAR: begin
        frame_mirror.delete();
        clears_sent++;
      end
      ldis_pkg::OP_PLOT, ldis_pkg::OP_READ: begin
        if (!in_frame) begin
          r.dropped = 1'b1;
          drops_sent++;
        end else if (op == ldis_pkg::OP_PLOT) begin
          r.value = grey_of_range(root_floor(coord_sq(x) + coord_sq(y) + coord_sq(z)));
          frame_mirror[addr] = r.value;
          plots_sent++;
        end else begin
          if (frame_mirror.exists(addr)) r.value = frame_mirror[addr];
          reads_sent++;
        end
      end
      default: unused_sent++;
    endcase
    return r;
  endfunction

  task automatic send_command(ldis_pkg::op_t op, ldis_pkg::col_t col, ldis_pkg::row_t row,
                              ldis_pkg::coord_t x, ldis_pkg::coord_t y,
                              ldis_pkg::coord_t z);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.pixel_col <= col;
    in_ch.pixel_row <= row;
    in_ch.point_x   <= x;
    in_ch.point_y   <= y;
    in_ch.point_z   <= z;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pixel_results_due.push_back(splat_predict(op, col, row, x, y, z));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pixel_results_due.size() != 0) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic program_frame(ldis_pkg::dist_t range_max, ldis_pkg::fw_t w,
                               ldis_pkg::fh_t h);
    ldis_pkg::cfg_idx_t  idx [3];
    ldis_pkg::cfg_data_t val [3];
    idx = '{ldis_pkg::REG_MAX_DISTANCE, ldis_pkg::REG_FRAME_WIDTH,
            ldis_pkg::REG_FRAME_HEIGHT};
    val = '{ldis_pkg::cfg_data_t'(range_max), ldis_pkg::cfg_data_t'(w),
            ldis_pkg::cfg_data_t'(h)};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
    max_dist_cfg = range_max;
    width_cfg    = w;
    height_cfg   = h;
  endtask

  function automatic ldis_pkg::coord_t draw_coord();
    int unsigned lim;
    int signed v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: return ldis_pkg::coord_t'($urandom());
      6, 7, 8: v = $urandom_range(0, 255);
      9, 10, 11: begin
        case ($urandom_range(0, 4))
          0: return ldis_pkg::coord_t'(-131072);
          1: return ldis_pkg::coord_t'(-1);
          2: return ldis_pkg::coord_t'(0);
          3: return ldis_pkg::coord_t'(1);
          default: return ldis_pkg::coord_t'(131071);
        endcase
      end
      default: begin
        // around max_distance so the range lands on both sides of it
        lim = (int'(max_dist_cfg) * 2) / 3;
        if (lim > 131071) lim = 131071;
        v = $urandom_range(0, lim);
      end
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return ldis_pkg::coord_t'(v);
  endfunction

  function automatic int unsigned pick_pixel(int unsigned span, int unsigned full);
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(0, full - 1);
      2: return (span > 0) ? span - 1 : 0;
      3: return span;  // first one past the frame edge
      default: return (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, full - 1);
    endcase
  endfunction

  task automatic test_reset_state();
    send_command(ldis_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_command(ldis_pkg::OP_READ, 1023, 511, 0, 0, 0);
  endtask

  task automatic test_plot_extremes();
    send_command(ldis_pkg::OP_PLOT, 0, 0, 0, 0, 0);
    send_command(ldis_pkg::OP_PLOT, 1023, 511, -131072, -131072, -131072);
    send_command(ldis_pkg::OP_PLOT, 5, 7, 1, 0, 0);
    send_command(ldis_pkg::OP_PLOT, 6, 7, -30000, 40000, 0);
    send_command(ldis_pkg::OP_PLOT, 7, 7, 131071, 0, -1);
    send_command(ldis_pkg::OP_PLOT, 8, 7, 0, 0, 49999);
    send_command(ldis_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_command(ldis_pkg::OP_READ, 5, 7, 0, 0, 0);
    send_command(ldis_pkg::OP_READ, 1023, 511, 0, 0, 0);
  endtask

  task automatic test_unused_op();
    send_command(OP_UNUSED, 5, 7, 131071, 131071, 131071);
    send_command(ldis_pkg::OP_READ, 5, 7, 0, 0, 0);
  endtask

  task automatic test_clear_frame();
    send_command(ldis_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_command(ldis_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_command(ldis_pkg::OP_READ, 5, 7, 0, 0, 0);
  endtask

  task automatic test_frame_bounds();
    drain_results();
    program_frame(1, 100, 50);
    send_command(ldis_pkg::OP_PLOT, 99, 49, 0, 0, 0);
    send_command(ldis_pkg::OP_PLOT, 100, 0, 7, 7, 7);
    send_command(ldis_pkg::OP_READ, 0, 50, 0, 0, 0);
    send_command(ldis_pkg::OP_PLOT, 3, 3, 1, 0, 0);
    send_command(ldis_pkg::OP_READ, 99, 49, 0, 0, 0);
    send_command(ldis_pkg::OP_READ, 3, 3, 0, 0, 0);
  endtask

  task automatic test_random_settings();
    ldis_pkg::dist_t range_max;
    ldis_pkg::fw_t w;
    ldis_pkg::fh_t h;
    int count, k, sel;
    int unsigned w_use, h_use;
    ldis_pkg::col_t pool_col [16];
    ldis_pkg::row_t pool_row [16];
    ldis_pkg::col_t col;
    ldis_pkg::row_t row;
    ldis_pkg::op_t op;
    for (int phase = 0; phase < PHASES; phase++) begin
      count = 180;
      case (phase)
        0: begin range_max = 50000;  w = 1024; h = 512;  end
        1: begin range_max = 262143; w = 2047; h = 1023; end
        2: begin range_max = 1;      w = 1;    h = 1;    end
        3: begin range_max = 0;      w = 640;  h = 480;  end
        4: begin range_max = 1000;   w = 0;    h = 512;  count = 40; end
        5: begin range_max = 1000;   w = 1024; h = 0;    count = 40; end
        6: begin range_max = 131072; w = 1023; h = 511;  end
        default: begin
          range_max = $urandom_range(1, 262143);
          w         = $urandom_range(1, 1024);
          h         = $urandom_range(1, 512);
        end
      endcase
      drain_results();
      program_frame(range_max, w, h);
      idle_on = (phase % 5) != 2;
      w_use = (w < ldis_pkg::MAX_WIDTH) ? w : ldis_pkg::MAX_WIDTH;
      h_use = (h < ldis_pkg::MAX_HEIGHT) ? h : ldis_pkg::MAX_HEIGHT;
      // small pixel pool so reads come back to plotted pixels
      for (int i = 0; i < 16; i++) begin
        pool_col[i] = ldis_pkg::col_t'(pick_pixel(w_use, ldis_pkg::MAX_WIDTH));
        pool_row[i] = ldis_pkg::row_t'(pick_pixel(h_use, ldis_pkg::MAX_HEIGHT));
      end
      for (int n = 0; n < count; n++) begin
        if (phase % 2 == 1 && n == count / 2) drain_results();
        k = $urandom_range(0, 15);
        col = pool_col[k];
        row = pool_row[k];
        if ($urandom_range(0, 9) == 0) begin
          col = ldis_pkg::col_t'(pick_pixel(w_use, ldis_pkg::MAX_WIDTH));
          row = ldis_pkg::row_t'(pick_pixel(h_use, ldis_pkg::MAX_HEIGHT));
        end
        sel = $urandom_range(0, 99);
        op = (sel < 50) ? ldis_pkg::OP_PLOT : (sel < 95) ? ldis_pkg::OP_READ : OP_UNUSED;
        send_command(op, col, row, draw_coord(), draw_coord(), draw_coord());
      end
    end
  endtask

  // result side: random stalls, each word checked against the oldest prediction
  initial begin : result_sink
    int stall;
    pixel_result_t due;
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_ch.valid === 1'b1 &&
                                  out_ch.ready === 1'b1));
      results_seen++;
      if (pixel_results_due.size() == 0) begin
        report_mismatch($sformatf("word with nothing due: value %0d dropped %0b",
                                  out_ch.pixel_value, out_ch.point_dropped));
      end else begin
        due = pixel_results_due.pop_front();
        if (out_ch.pixel_value !== due.value)
          report_mismatch($sformatf("word %0d pixel_value %0d, want %0d",
                                    results_seen, out_ch.pixel_value, due.value));
        if (out_ch.point_dropped !== due.dropped)
          report_mismatch($sformatf("word %0d point_dropped %0b, want %0b",
                                    results_seen, out_ch.point_dropped, due.dropped));
      end
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.op        <= ldis_pkg::OP_CLEAR;
    in_ch.pixel_col <= '0;
    in_ch.pixel_row <= '0;
    in_ch.point_x   <= '0;
    in_ch.point_y   <= '0;
    in_ch.point_z   <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= ldis_pkg::REG_MAX_DISTANCE;
    cfg_ch.data     <= '0;
    rst_n           <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_plot_extremes();
    test_unused_op();
    test_clear_frame();
    test_frame_bounds();
    test_random_settings();

    drain_results();
    repeat (40) @(posedge clk);
    $display("covered %0d plots, %0d reads, %0d dropped, %0d clears, %0d unused commands",
             plots_sent, reads_sent, drops_sent, clears_sent, unused_sent);
    $display("over %0d register settings; %0d words checked, %0d mismatches",
             PHASES + 2, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("lidar_depth_image_splatter regression: pass");
    end else begin
      $display("lidar_depth_image_splatter regression: fail");
    end
    $finish;
  end

  // reset clearing pass, one clear and about 1900 words, with a wide margin
  initial begin
    #100_000_000;
    $display("lidar_depth_image_splatter regression: fail");
    $finish;
  end

endmodule
